// ----- rtl/hwp_pkg.sv -----
// Shared item types and character codes for the hex text word parser.
`timescale 1ns / 1ps
`default_nettype none

package hwp_pkg;

	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_HASH    = 8'h23;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_mark;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] word_value;
		logic [7:0]  bad_char;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic [15:0] words_written;
		logic        last;
	} out_item_t;

	// Results produced by one character: up to two, in order.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} res_push_t;

endpackage

`default_nettype wire

// ----- rtl/hex_text_word_parser.sv -----
// Top level of the hex text word parser: input register, parser core, result queue.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+------------------------------
//   input   | char_valid | char_ready | char_item (hwp_pkg::in_item_t)
//   result  | res_valid  | res_ready  | res_item  (hwp_pkg::out_item_t)
//
// One character is taken per cycle while the queue has room; it is registered,
// parsed once the queue has room, and its results can leave the queue the cycle after that.
// A character that yields two results is still taken as one input item; the result
// side then drains one item per cycle while res_ready is high from a four-entry queue.
// The input side stalls only while that queue holds more than two items.
// Reset puts the parser between tokens on line 1, column 0, with no words.
`timescale 1ns / 1ps
`default_nettype none

module hex_text_word_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_ready,
	input  wire hwp_pkg::in_item_t char_item,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output hwp_pkg::out_item_t     res_item
);

	logic               valid_s1;
	hwp_pkg::in_item_t  item_s1;
	logic               room;
	logic               go;
	hwp_pkg::res_push_t push;

	assign go         = valid_s1 && room;
	assign char_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_item;
		end
	end

	hwp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.push   (push)
	);

	hwp_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (res_valid),
		.ready  (res_ready),
		.item   (res_item)
	);

endmodule

`default_nettype wire

// ----- rtl/hwp_core.sv -----
// Parser state and the per-character next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module hwp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire hwp_pkg::in_item_t item,
	output hwp_pkg::res_push_t     push
);

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_NUMBER  = 2'd1,
		MODE_COMMENT = 2'd2,
		MODE_HALTED  = 2'd3
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] line_q, line_d;
	logic [15:0] col_q, col_d;
	logic [15:0] words_q, words_d;

	logic                has_word;
	logic                has_tail;
	hwp_pkg::kind_t      tail_kind;
	logic [7:0]          tail_bad;
	logic [4:0]          hx;
	hwp_pkg::out_item_t  word_res;
	hwp_pkg::out_item_t  tail_res;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			r = {1'b1, 4'(ch - 8'h30)};
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			r = {1'b1, 4'(ch - 8'h37)};
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			r = {1'b1, 4'(ch - 8'h57)};
		end
		return r;
	endfunction

	assign hx = hex_digit(item.char_code);

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		line_d    = line_q;
		col_d     = col_q;
		words_d   = words_q;
		has_word  = 1'b0;
		has_tail  = 1'b0;
		tail_kind = hwp_pkg::KIND_DONE;
		tail_bad  = 8'd0;
		unique case (mode_q)
			MODE_HALTED: begin
			end
			MODE_COMMENT: begin
				if (item.end_mark) begin
					has_tail = 1'b1;
					mode_d   = MODE_HALTED;
				end else if (item.char_code == hwp_pkg::CHAR_NEWLINE) begin
					line_d = sat_inc(line_q);
					col_d  = 16'd0;
					mode_d = MODE_IDLE;
				end
			end
			MODE_IDLE, MODE_NUMBER: begin
				col_d = sat_inc(col_q);
				if (mode_q == MODE_NUMBER && !item.end_mark && hx[4]) begin
					acc_d = {acc_q[11:0], hx[3:0]};
				end else begin
					// A number in progress is closed by any non-digit or by the end mark.
					if (mode_q == MODE_NUMBER) begin
						has_word = 1'b1;
						words_d  = sat_inc(words_q);
						acc_d    = 16'd0;
						mode_d   = MODE_IDLE;
					end
					priority if (item.end_mark) begin
						has_tail = 1'b1;
						mode_d   = MODE_HALTED;
					end else if (item.char_code == hwp_pkg::CHAR_SPACE) begin
					end else if (item.char_code == hwp_pkg::CHAR_NEWLINE) begin
						line_d = sat_inc(line_q);
						col_d  = 16'd0;
					end else if (item.char_code == hwp_pkg::CHAR_HASH) begin
						mode_d = MODE_COMMENT;
					end else if (hx[4]) begin
						acc_d  = {12'd0, hx[3:0]};
						mode_d = MODE_NUMBER;
					end else begin
						has_tail  = 1'b1;
						tail_kind = hwp_pkg::KIND_ERROR;
						tail_bad  = item.char_code;
						mode_d    = MODE_HALTED;
					end
				end
			end
		endcase
	end

	// A word reports the column of the character that closes it, taken before a
	// closing newline moves to the next line.
	always_comb begin
		word_res.kind          = hwp_pkg::KIND_WORD;
		word_res.word_value    = acc_q;
		word_res.bad_char      = 8'd0;
		word_res.line_number   = line_q;
		word_res.column_number = sat_inc(col_q);
		word_res.words_written = words_d;
		word_res.last          = !has_tail;
		tail_res.kind          = tail_kind;
		tail_res.word_value    = 16'd0;
		tail_res.bad_char      = tail_bad;
		tail_res.line_number   = line_d;
		tail_res.column_number = col_d;
		tail_res.words_written = words_d;
		tail_res.last          = 1'b1;
		push.count  = go ? (2'(has_word) + 2'(has_tail)) : 2'd0;
		push.first  = has_word ? word_res : tail_res;
		push.second = tail_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= 16'd0;
			line_q  <= 16'd1;
			col_q   <= 16'd0;
			words_q <= 16'd0;
		end else if (go) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			line_q  <= line_d;
			col_q   <= col_d;
			words_q <= words_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hwp_res_queue.sv -----
// Small result queue that takes up to two items per cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module hwp_res_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hwp_pkg::res_push_t push,
	output logic                    room,
	output logic                    valid,
	input  wire logic               ready,
	output hwp_pkg::out_item_t      item
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hwp_pkg::out_item_t slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign valid = (count_q != '0);
	assign item  = slots_q[rd_ptr_q];
	assign pop   = valid && ready;
	// Room for two more items regardless of what leaves this cycle.
	assign room  = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slots_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slots_q[wr_ptr_q + PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hwp_checker.sv -----
// Port-level checks for the hex text word parser and their binding.
`timescale 1ns / 1ps
`default_nettype none

module hwp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire hwp_pkg::out_item_t res_item
);

	// A waiting result holds still until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// Done and error always close the results of their character.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind != hwp_pkg::KIND_WORD |-> res_item.last)
		else $error("final result without last");

	// Nothing follows a done or error result.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_item.kind != hwp_pkg::KIND_WORD |=> !res_valid)
		else $error("result after parser halted");

	// A data word counts itself and carries no error character.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind == hwp_pkg::KIND_WORD |->
			res_item.words_written != 16'd0 && res_item.bad_char == 8'd0)
		else $error("malformed data word");

endmodule

bind hex_text_word_parser hwp_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);

`default_nettype wire

// ----- tb/sv/hex_text_word_parser_tb.sv -----
// Self-checking testbench for the hex text word parser: text stimulus, prediction, checking.
`timescale 1ns / 1ps

module hex_text_word_parser_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int NOT_HEX = 16;
	localparam int SETTLE_CYCLES = 20;

	typedef enum logic [1:0] {
		PM_IDLE    = 2'd0,
		PM_NUMBER  = 2'd1,
		PM_COMMENT = 2'd2,
		PM_HALTED  = 2'd3
	} parse_mode_t;

	typedef enum int {
		STOP_END_AFTER_NUMBER,
		STOP_BAD_AFTER_NUMBER,
		STOP_END_IN_COMMENT,
		STOP_END_BETWEEN,
		STOP_BAD_BETWEEN
	} stop_kind_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_ready;
	hwp_pkg::in_item_t  char_item = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	hwp_pkg::out_item_t res_item;

	hex_text_word_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

	// Shadow copy of the parser state.
	parse_mode_t mode = PM_IDLE;
	logic [15:0] acc = 16'd0;
	logic [15:0] line_no = 16'd1;
	logic [15:0] col_no = 16'd0;
	logic [15:0] word_total = 16'd0;

	hwp_pkg::out_item_t expected_results[$];
	hwp_pkg::out_item_t expected_head;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        errors = 0;
	int        chars_sent = 0;
	int        results_checked = 0;
	int        cycle_count = 0;
	string     stop_label = "none";
	string     hex_chars = "0123456789ABCDEFabcdef";

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
			expected_results.size());
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return NOT_HEX;
	endfunction

	function automatic hwp_pkg::out_item_t make_result(input hwp_pkg::kind_t kind,
		input logic [15:0] value, input logic [7:0] bad);
		hwp_pkg::out_item_t r;
		r.kind = kind;
		r.word_value = value;
		r.bad_char = bad;
		r.line_number = line_no;
		r.column_number = col_no;
		r.words_written = word_total;
		r.last = 1'b0;
		return r;
	endfunction

	// Advances the shadow state by one item and queues the results it causes.
	task automatic predict_char(input hwp_pkg::in_item_t it);
		hwp_pkg::out_item_t produced[$];
		hwp_pkg::out_item_t r;
		int d;
		bit absorbed;
		absorbed = 1'b0;
		if (mode == PM_COMMENT) begin
			if (it.end_mark) begin
				produced.push_back(make_result(hwp_pkg::KIND_DONE, 16'd0, 8'd0));
				mode = PM_HALTED;
			end else if (it.char_code == hwp_pkg::CHAR_NEWLINE) begin
				line_no = sat16(line_no);
				col_no = 16'd0;
				mode = PM_IDLE;
			end
		end else if (mode != PM_HALTED) begin
			col_no = sat16(col_no);
			d = hex_digit(it.char_code);
			if (mode == PM_NUMBER) begin
				if (!it.end_mark && d < NOT_HEX) begin
					acc = {acc[11:0], d[3:0]};
					absorbed = 1'b1;
				end else begin
					word_total = sat16(word_total);
					produced.push_back(make_result(hwp_pkg::KIND_WORD, acc, 8'd0));
					acc = 16'd0;
					mode = PM_IDLE;
				end
			end
			if (!absorbed) begin
				if (it.end_mark) begin
					produced.push_back(make_result(hwp_pkg::KIND_DONE, 16'd0, 8'd0));
					mode = PM_HALTED;
				end else if (it.char_code == hwp_pkg::CHAR_NEWLINE) begin
					line_no = sat16(line_no);
					col_no = 16'd0;
				end else if (it.char_code == hwp_pkg::CHAR_HASH) begin
					mode = PM_COMMENT;
				end else if (it.char_code != hwp_pkg::CHAR_SPACE) begin
					if (d < NOT_HEX) begin
						acc = {12'd0, d[3:0]};
						mode = PM_NUMBER;
					end else begin
						produced.push_back(make_result(hwp_pkg::KIND_ERROR, 16'd0,
							it.char_code));
						mode = PM_HALTED;
					end
				end
			end
		end
		foreach (produced[i]) begin
			r = produced[i];
			r.last = (i == produced.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	// Valid is only lowered when a gap is inserted, so back-to-back items keep it high.
	task automatic send_item(input hwp_pkg::in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		predict_char(it);
		chars_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		hwp_pkg::in_item_t it;
		it.char_code = c;
		it.end_mark = 1'b0;
		send_item(it);
	endtask

	task automatic send_end_mark();
		hwp_pkg::in_item_t it;
		it.char_code = 8'($urandom_range(255));
		it.end_mark = 1'b1;
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_number(input int digits);
		for (int i = 0; i < digits; i++)
			send_byte(hex_chars[$urandom_range(hex_chars.len() - 1)]);
	endtask

	// Comment body: any byte but a newline, then the closing newline.
	task automatic send_comment(input int body_len);
		logic [7:0] c;
		send_byte(hwp_pkg::CHAR_HASH);
		for (int i = 0; i < body_len; i++) begin
			c = 8'($urandom_range(255));
			while (c == hwp_pkg::CHAR_NEWLINE) c = 8'($urandom_range(255));
			send_byte(c);
		end
		send_byte(hwp_pkg::CHAR_NEWLINE);
	endtask

	function automatic logic [7:0] pick_bad_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while (hex_digit(c) != NOT_HEX || c == hwp_pkg::CHAR_SPACE
			|| c == hwp_pkg::CHAR_NEWLINE || c == hwp_pkg::CHAR_HASH)
			c = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, res_item);
				errors++;
			end else begin
				expected_head = expected_results.pop_front();
				check_field("kind", 16'(expected_head.kind), 16'(res_item.kind));
				check_field("word_value", expected_head.word_value, res_item.word_value);
				check_field("bad_char", 16'(expected_head.bad_char), 16'(res_item.bad_char));
				check_field("line_number", expected_head.line_number, res_item.line_number);
				check_field("column_number", expected_head.column_number,
					res_item.column_number);
				check_field("words_written", expected_head.words_written,
					res_item.words_written);
				check_field("last", 16'(expected_head.last), 16'(res_item.last));
				results_checked++;
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Digits of every case, separators, a long number, a comment with extreme bytes,
	// and a number closed directly by a comment.
	task automatic test_directed();
		send_text("0 fF 9aA\n");
		send_text("12345 ");
		send_byte(hwp_pkg::CHAR_HASH);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(hwp_pkg::CHAR_NEWLINE);
		send_text("E#\n");
	endtask

	task automatic test_random_text(input int target);
		int start;
		int pick;
		start = chars_sent;
		while (chars_sent - start < target) begin
			pick = $urandom_range(9);
			if (pick <= 5) begin
				send_number(($urandom_range(7) == 0) ? $urandom_range(5, 9)
					: $urandom_range(1, 4));
				case ($urandom_range(3))
					0: send_byte(hwp_pkg::CHAR_SPACE);
					1: send_byte(hwp_pkg::CHAR_NEWLINE);
					2: send_comment($urandom_range(0, 6));
					default: send_text("   ");
				endcase
			end else if (pick <= 7) begin
				send_comment($urandom_range(0, 10));
			end else if (pick == 8) begin
				send_byte(hwp_pkg::CHAR_SPACE);
			end else begin
				send_byte(hwp_pkg::CHAR_NEWLINE);
			end
		end
	endtask

	task automatic test_termination();
		stop_kind_t how;
		how = stop_kind_t'($urandom_range(4));
		case (how)
			STOP_END_AFTER_NUMBER: begin
				stop_label = "end of input closing a number";
				send_number($urandom_range(1, 6));
				send_end_mark();
			end
			STOP_BAD_AFTER_NUMBER: begin
				stop_label = "an invalid character closing a number";
				send_number($urandom_range(1, 6));
				send_byte(pick_bad_char());
			end
			STOP_END_IN_COMMENT: begin
				stop_label = "end of input inside a comment";
				send_text(" ");
				send_byte(hwp_pkg::CHAR_HASH);
				send_byte(pick_bad_char());
				send_byte(8'hFF);
				send_end_mark();
			end
			STOP_END_BETWEEN: begin
				stop_label = "end of input between tokens";
				send_text(" ");
				send_end_mark();
			end
			default: begin
				stop_label = "an invalid character between tokens";
				send_text("\n");
				send_byte(pick_bad_char());
			end
		endcase
	endtask

	// Once halted, nothing may produce a result.
	task automatic test_halted_input();
		hwp_pkg::in_item_t it;
		for (int i = 0; i < 24; i++) begin
			it.char_code = 8'($urandom_range(255));
			it.end_mark = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	initial begin
		send_idle_pct = 13;
		recv_idle_pct = 80;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_text(410);

		send_idle_pct = 80;
		recv_idle_pct = 13;
		test_random_text(420);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_termination();
		test_halted_input();

		char_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items across three handshake pressure phases and checked %0d results,",
			chars_sent, results_checked);
		$display("with the input stopped by %s and then fed to a halted parser.", stop_label);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
